### design/pcpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel clock and porch planner package
// Shared widths, status codes and defaults of the planner.
// ----------------------------------------------------------------------------
package pcpp_pkg;

  localparam int unsigned RateW = 32;
  localparam int unsigned DivW  = 5;
  localparam int unsigned StatW = 3;

  localparam logic [31:0] PllARateDef   = 32'd1660000000;
  localparam logic [31:0] PllBRateDef   = 32'd1920000000;
  localparam logic [31:0] PllCRateDef   = 32'd1200000000;
  localparam int unsigned DivLimitDef   = 20;
  localparam logic [31:0] MaxPipeDef    = 32'd645000000;

  localparam logic [31:0] Scale = 32'd100;
  localparam logic [31:0] Micro = 32'd1000;

  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StNotNeed  = 3'd1;
  localparam logic [StatW-1:0] StNoDiv    = 3'd2;
  localparam logic [StatW-1:0] StRange    = 3'd3;
  localparam logic [StatW-1:0] StZeroDiv  = 3'd4;

  localparam logic [2:0] RegPanelRate = 3'd0;
  localparam logic [2:0] RegHActive   = 3'd1;
  localparam logic [2:0] RegVActive   = 3'd2;
  localparam logic [2:0] RegVBlank    = 3'd3;
  localparam logic [2:0] RegHBack     = 3'd4;
  localparam logic [2:0] RegHFront    = 3'd5;
  localparam logic [2:0] RegHSync     = 3'd6;
  localparam logic [2:0] RegPanelDiv  = 3'd7;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [31:0]      pipe_rate;
    logic [DivW-1:0]  pipe_divider;
    logic [31:0]      new_back_porch;
    logic [31:0]      new_front_porch;
    logic [31:0]      new_sync_width;
  } result_t;

  // Divider handshake between sequencer and shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

### design/pcpp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planner stream interfaces
// Valid/ready channels for the request and the result beats.
// ----------------------------------------------------------------------------
interface pcpp_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] requested_rate;
  modport source (output valid, output requested_rate, input ready);
  modport sink   (input valid, input requested_rate, output ready);
endinterface

interface pcpp_res_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic [31:0]             pipe_rate;
  logic [4:0]              pipe_divider;
  logic [31:0]             new_back_porch;
  logic [31:0]             new_front_porch;
  logic [31:0]             new_sync_width;
  modport source (output valid, output status, output pipe_rate, output pipe_divider,
                  output new_back_porch, output new_front_porch,
                  output new_sync_width, input ready);
  modport sink   (input valid, input status, input pipe_rate, input pipe_divider,
                  input new_back_porch, input new_front_porch,
                  input new_sync_width, output ready);
endinterface
`default_nettype wire

### design/pcpp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planner shared divider
// Restoring 64-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcpp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pcpp_pkg::div_req_t req_i,
  output pcpp_pkg::div_rsp_t      rsp_o
);

  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start && !busy_q) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 7'd0) else $error("divider count left over");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("divider busy with empty count");

endmodule
`default_nettype wire

### design/pcpp_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planner sequencer
// Steps the rate search and porch arithmetic through the shared divider.
// ----------------------------------------------------------------------------
module pcpp_seq #(
  parameter logic [31:0] PllARate = pcpp_pkg::PllARateDef,
  parameter logic [31:0] PllBRate = pcpp_pkg::PllBRateDef,
  parameter logic [31:0] PllCRate = pcpp_pkg::PllCRateDef,
  parameter int unsigned DivLimit = pcpp_pkg::DivLimitDef,
  parameter logic [31:0] MaxPipe  = pcpp_pkg::MaxPipeDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        req_rate_i,
  input  wire logic [31:0]        panel_rate_i,
  input  wire logic [12:0]        h_active_i,
  input  wire logic [12:0]        v_active_i,
  input  wire logic [11:0]        v_blank_i,
  input  wire logic [11:0]        h_back_i,
  input  wire logic [11:0]        h_front_i,
  input  wire logic [11:0]        h_sync_i,
  input  wire logic [3:0]         panel_div_i,
  output logic                    done_o,
  output pcpp_pkg::result_t       res_o,
  output pcpp_pkg::div_req_t      dreq_o,
  input  wire pcpp_pkg::div_rsp_t drsp_i
);

  localparam int unsigned DlW = $clog2(DivLimit + 1);

  // Sequencer states.
  localparam logic [4:0] SIdle    = 5'd0;
  localparam logic [4:0] SCandDiv = 5'd1;  // pll / d for the search
  localparam logic [4:0] SCandCl  = 5'd2;  // pll / dfound for the ceiling
  localparam logic [4:0] SPipe    = 5'd3;  // rate / d against the panel rate
  localparam logic [4:0] SCheck   = 5'd4;
  localparam logic [4:0] SPDiv    = 5'd5;  // p / 100
  localparam logic [4:0] SRNDiv   = 5'd6;  // rate_new / 100
  localparam logic [4:0] SRatio   = 5'd7;
  localparam logic [4:0] SMulA    = 5'd8;
  localparam logic [4:0] SFps1    = 5'd9;  // p / hsz
  localparam logic [4:0] SFps2    = 5'd10; // * 100 / vsz
  localparam logic [4:0] STFrame  = 5'd11;
  localparam logic [4:0] SThLine  = 5'd12;
  localparam logic [4:0] STbp     = 5'd13;
  localparam logic [4:0] SNfp     = 5'd14;
  localparam logic [4:0] SCeil    = 5'd15; // three porches by 100
  localparam logic [4:0] SPanDiv  = 5'd16; // three porches by panel divider
  localparam logic [4:0] SDone    = 5'd17;

  logic [4:0]     st_q, st_d;
  logic           wait_q, wait_d;
  logic [1:0]     pll_q, pll_d;
  logic [DlW-1:0] d_q, d_d;
  logic [31:0]    rate_q, rate_d;
  logic [31:0]    a_q, a_d;   // scratch: p/100, then fps, tframe
  logic [31:0]    b_q, b_d;   // scratch: ratio, thline
  logic [31:0]    tbp_q, tbp_d;
  logic [31:0]    bp_q, bp_d, fp_q, fp_d, pw_q, pw_d;
  logic [31:0]    hsz_q, hsz_d;
  logic [1:0]     k_q, k_d;
  pcpp_pkg::result_t res_q, res_d;
  pcpp_pkg::div_req_t dreq;
  logic [31:0]    pll_rate;
  logic [31:0]    vsz;
  logic [31:0]    quo32;
  logic [31:0]    mulv;
  logic [31:0]    ksel;
  logic           dnz;
  logic           scale_en;
  logic [31:0]    thl_num;
  logic [31:0]    tbp_num;
  logic [31:0]    nfp_num;

  always_comb begin
    case (pll_q)
      2'd0:    pll_rate = PllARate;
      2'd1:    pll_rate = PllBRate;
      default: pll_rate = PllCRate;
    endcase
    case (k_q)
      2'd0:    ksel = res_q.new_back_porch;
      2'd1:    ksel = res_q.new_front_porch;
      default: ksel = res_q.new_sync_width;
    endcase
  end

  assign vsz      = 32'(v_active_i) + 32'(v_blank_i);
  assign quo32    = drsp_i.quotient[31:0];
  assign dnz      = drsp_i.remainder != 64'd0;
  assign scale_en = panel_div_i > 4'd1;
  assign mulv     = scale_en ? 32'(panel_div_i) : 32'd1;

  // The dividends below wrap at 32 bits before they reach the divider.
  assign thl_num = pcpp_pkg::Scale * a_q;
  assign tbp_num = b_q * (bp_q + pw_q);
  assign nfp_num = (res_q.new_back_porch + res_q.new_sync_width) * b_q;

  always_comb begin
    st_d   = st_q;   wait_d = wait_q; pll_d = pll_q; d_d = d_q;
    rate_d = rate_q; a_d = a_q; b_d = b_q; tbp_d = tbp_q;
    bp_d = bp_q; fp_d = fp_q; pw_d = pw_q; hsz_d = hsz_q; k_d = k_q;
    res_d  = res_q;
    dreq   = '0;
    done_o = 1'b0;
    case (st_q)
      SIdle: begin
        if (start_i) begin
          res_d = '0;
          if (32'(req_rate_i) <= panel_rate_i) begin
            res_d.status = pcpp_pkg::StNotNeed;
            st_d = SDone;
          end else begin
            rate_d = PllARate;
            pll_d  = 2'd0;
            d_d    = DlW'(1);
            wait_d = 1'b0;
            st_d   = SCandDiv;
          end
        end
      end
      SCandDiv: begin
        if (pll_rate < req_rate_i) begin
          if (pll_q == 2'd2) begin
            d_d = DlW'(1); st_d = SPipe;
          end else begin
            pll_d = pll_q + 2'd1; d_d = DlW'(1);
          end
        end else if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(pll_rate); dreq.divisor = 64'(d_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0;
          if (quo32 < req_rate_i || 32'(d_q) == DivLimit - 1) begin
            // Largest divider that still meets the request.
            if (quo32 < req_rate_i) d_d = d_q - DlW'(1);
            st_d = SCandCl;
          end else begin
            d_d = d_q + DlW'(1);
          end
        end
      end
      SCandCl: begin
        if (d_q == '0) begin
          st_d = (pll_q == 2'd2) ? SPipe : SCandDiv;
          pll_d = (pll_q == 2'd2) ? pll_q : pll_q + 2'd1;
          d_d = DlW'(1);
        end else if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(pll_rate); dreq.divisor = 64'(d_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0;
          if ((quo32 + 32'(dnz)) != 32'd0 && rate_q > (quo32 + 32'(dnz)))
            rate_d = quo32 + 32'(dnz);
          st_d = (pll_q == 2'd2) ? SPipe : SCandDiv;
          pll_d = (pll_q == 2'd2) ? pll_q : pll_q + 2'd1;
          d_d = DlW'(1);
        end
      end
      SPipe: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(rate_q); dreq.divisor = 64'(d_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0;
          if (quo32 < panel_rate_i || 32'(d_q) == DivLimit - 1) begin
            if (quo32 < panel_rate_i) d_d = d_q - DlW'(1);
            st_d = SCheck;
          end else begin
            d_d = d_q + DlW'(1);
          end
        end
      end
      SCheck: begin
        res_d.pipe_rate = rate_q;
        if (d_q == '0) begin
          res_d.status = pcpp_pkg::StNoDiv; st_d = SDone;
        end else if (!wait_q) begin
          res_d.pipe_divider = 5'(d_q);
          dreq.start = 1'b1; dreq.dividend = 64'(rate_q); dreq.divisor = 64'(d_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0;
          b_d = quo32;  // rate_new
          if (quo32 < panel_rate_i || rate_q > MaxPipe) begin
            res_d.status = pcpp_pkg::StRange; st_d = SDone;
          end else if (quo32 > panel_rate_i) begin
            bp_d = 32'(h_back_i) * mulv;
            fp_d = 32'(h_front_i) * mulv;
            pw_d = 32'(h_sync_i) * mulv;
            st_d = SPDiv;
          end else begin
            res_d.new_back_porch  = 32'(h_back_i);
            res_d.new_front_porch = 32'(h_front_i);
            res_d.new_sync_width  = 32'(h_sync_i);
            st_d = SDone;
          end
        end
      end
      SPDiv: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(panel_rate_i);
          dreq.divisor = 64'(pcpp_pkg::Scale);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; a_d = quo32;
          hsz_d = 32'(h_active_i) + bp_q + fp_q + pw_q;
          if (quo32 == 32'd0) begin
            res_d.status = pcpp_pkg::StZeroDiv; st_d = SDone;
          end else st_d = SRNDiv;
        end
      end
      SRNDiv: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(b_q); dreq.divisor = 64'(pcpp_pkg::Scale);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; b_d = quo32; st_d = SRatio;
        end
      end
      SRatio: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(b_q) * 64'(pcpp_pkg::Scale);
          dreq.divisor = 64'(a_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; b_d = quo32; st_d = SMulA;
        end
      end
      SMulA: begin
        // b_q holds the ratio; form scaled back porch and sync width.
        if (hsz_q == 32'd0 || vsz == 32'd0) begin
          res_d.status = pcpp_pkg::StZeroDiv; st_d = SDone;
        end else begin
          res_d.new_back_porch = bp_q * b_q;
          res_d.new_sync_width = pw_q * b_q;
          st_d = SFps1;
        end
      end
      SFps1: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(panel_rate_i); dreq.divisor = 64'(hsz_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; a_d = quo32; st_d = SFps2;
        end
      end
      SFps2: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(a_q) * 64'(pcpp_pkg::Scale);
          dreq.divisor = 64'(vsz);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; a_d = quo32;
          if (quo32 == 32'd0) begin
            res_d.new_back_porch = '0;
            res_d.new_sync_width = '0;
            res_d.status = pcpp_pkg::StZeroDiv; st_d = SDone;
          end else st_d = STFrame;
        end
      end
      STFrame: begin
        if (!wait_q) begin
          dreq.start = 1'b1;
          dreq.dividend = 64'(pcpp_pkg::Micro * pcpp_pkg::Micro * pcpp_pkg::Scale);
          dreq.divisor = 64'(a_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; a_d = quo32; st_d = SThLine;
        end
      end
      SThLine: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(thl_num);
          dreq.divisor = 64'(vsz);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; b_d = quo32; st_d = STbp;
        end
      end
      STbp: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(tbp_num);
          dreq.divisor = 64'(hsz_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0; tbp_d = quo32;
          if (quo32 == 32'd0) begin
            res_d.new_back_porch = '0;
            res_d.new_sync_width = '0;
            res_d.status = pcpp_pkg::StZeroDiv; st_d = SDone;
          end else st_d = SNfp;
        end
      end
      SNfp: begin
        if (!wait_q) begin
          dreq.start = 1'b1;
          dreq.dividend = 64'(nfp_num);
          dreq.divisor = 64'(tbp_q);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0;
          res_d.new_front_porch = quo32 - (32'(h_active_i) * pcpp_pkg::Scale
                                  + res_q.new_back_porch + res_q.new_sync_width);
          k_d = 2'd0; st_d = SCeil;
        end
      end
      SCeil, SPanDiv: begin
        if (!wait_q) begin
          dreq.start = 1'b1; dreq.dividend = 64'(ksel);
          dreq.divisor = (st_q == SCeil) ? 64'(pcpp_pkg::Scale) : 64'(panel_div_i);
          wait_d = 1'b1;
        end else if (drsp_i.done) begin
          wait_d = 1'b0;
          case (k_q)
            2'd0:    res_d.new_back_porch  = quo32 + ((st_q == SCeil) ? 32'(dnz) : 32'd0);
            2'd1:    res_d.new_front_porch = quo32 + ((st_q == SCeil) ? 32'(dnz) : 32'd0);
            default: res_d.new_sync_width  = quo32 + ((st_q == SCeil) ? 32'(dnz) : 32'd0);
          endcase
          if (k_q == 2'd2) begin
            k_d = 2'd0;
            res_d.status = pcpp_pkg::StOk;
            st_d = (st_q == SCeil && scale_en) ? SPanDiv : SDone;
          end else k_d = k_q + 2'd1;
        end
      end
      SDone: begin
        done_o = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      wait_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pll_q <= pll_d; d_q <= d_d; rate_q <= rate_d; a_q <= a_d; b_q <= b_d;
    tbp_q <= tbp_d; bp_q <= bp_d; fp_q <= fp_d; pw_q <= pw_d; hsz_q <= hsz_d;
    k_q <= k_d; res_q <= res_d;
  end

  assign res_o  = res_q;
  assign dreq_o = dreq;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp_i.busy) else $error("divider started while busy");
  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp_i.busy |-> wait_q) else $error("divider running unattended");
  a_done_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> st_q == SIdle) else $error("sequencer did not return to idle");

endmodule
`default_nettype wire

### design/pixel_clock_and_porch_planner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel clock and porch planner
// Picks a pipe clock from three PLLs and recomputes the horizontal porches.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and yields one result beat. All
// divisions go through one shared 64-bit restoring divider at one quotient bit
// per cycle. A request uses at most 95 divisions (up to 19 trial divisions and
// one rounding division for each PLL, up to 19 trial divisions and one check
// for the pipe divider, then 15 for the porch arithmetic). A request at or
// below the panel rate passes from the start register through the done state
// to the result register with no division. A new request is not taken until
// the previous result beat has been taken.
// ----------------------------------------------------------------------------
module pixel_clock_and_porch_planner #(
  parameter logic [31:0] PllARate = pcpp_pkg::PllARateDef,
  parameter logic [31:0] PllBRate = pcpp_pkg::PllBRateDef,
  parameter logic [31:0] PllCRate = pcpp_pkg::PllCRateDef,
  parameter int unsigned DivLimit = pcpp_pkg::DivLimitDef,
  parameter logic [31:0] MaxPipe  = pcpp_pkg::MaxPipeDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pcpp_req_if.sink         req,
  pcpp_res_if.source       res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] panel_rate_q;
  logic [12:0] h_active_q, v_active_q;
  logic [11:0] v_blank_q, h_back_q, h_front_q, h_sync_q;
  logic [3:0]  panel_div_q;
  logic        busy_q;
  logic        ovalid_q;
  logic [31:0] rate_in_q;
  logic        start_q;
  logic        seq_done;
  logic        wr_en;
  logic        in_acc;
  logic [2:0]  ridx;
  pcpp_pkg::result_t  seq_res, out_q;
  pcpp_pkg::div_req_t dreq;
  pcpp_pkg::div_rsp_t drsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_rate_q <= 32'd148500000;
      h_active_q   <= 13'd1080;
      v_active_q   <= 13'd2340;
      v_blank_q    <= 12'd40;
      h_back_q     <= 12'd20;
      h_front_q    <= 12'd20;
      h_sync_q     <= 12'd10;
      panel_div_q  <= 4'd1;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (ridx)
        pcpp_pkg::RegPanelRate: panel_rate_q <= pwdata;
        pcpp_pkg::RegHActive:   h_active_q   <= pwdata[12:0];
        pcpp_pkg::RegVActive:   v_active_q   <= pwdata[12:0];
        pcpp_pkg::RegVBlank:    v_blank_q    <= pwdata[11:0];
        pcpp_pkg::RegHBack:     h_back_q     <= pwdata[11:0];
        pcpp_pkg::RegHFront:    h_front_q    <= pwdata[11:0];
        pcpp_pkg::RegHSync:     h_sync_q     <= pwdata[11:0];
        pcpp_pkg::RegPanelDiv:  panel_div_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      pcpp_pkg::RegPanelRate: prdata = panel_rate_q;
      pcpp_pkg::RegHActive:   prdata = 32'(h_active_q);
      pcpp_pkg::RegVActive:   prdata = 32'(v_active_q);
      pcpp_pkg::RegVBlank:    prdata = 32'(v_blank_q);
      pcpp_pkg::RegHBack:     prdata = 32'(h_back_q);
      pcpp_pkg::RegHFront:    prdata = 32'(h_front_q);
      pcpp_pkg::RegHSync:     prdata = 32'(h_sync_q);
      default:                prdata = 32'(panel_div_q);
    endcase
  end

  // Busy from the accepted beat until the sequencer posts its result; a
  // waiting result beat also holds off the next request.
  assign req.ready = !busy_q && !ovalid_q;
  assign in_acc    = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      start_q  <= 1'b0;
    end else begin
      start_q <= in_acc;
      if (in_acc) busy_q <= 1'b1;
      else if (seq_done) busy_q <= 1'b0;
      if (seq_done) ovalid_q <= 1'b1;
      else if (res.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) rate_in_q <= req.requested_rate;
    if (seq_done) out_q <= seq_res;
  end

  pcpp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  pcpp_seq #(
    .PllARate (PllARate),
    .PllBRate (PllBRate),
    .PllCRate (PllCRate),
    .DivLimit (DivLimit),
    .MaxPipe  (MaxPipe)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_q),
    .req_rate_i   (rate_in_q),
    .panel_rate_i (panel_rate_q),
    .h_active_i   (h_active_q),
    .v_active_i   (v_active_q),
    .v_blank_i    (v_blank_q),
    .h_back_i     (h_back_q),
    .h_front_i    (h_front_q),
    .h_sync_i     (h_sync_q),
    .panel_div_i  (panel_div_q),
    .done_o       (seq_done),
    .res_o        (seq_res),
    .dreq_o       (dreq),
    .drsp_i       (drsp)
  );

  assign res.valid           = ovalid_q;
  assign res.status          = out_q.status;
  assign res.pipe_rate       = out_q.pipe_rate;
  assign res.pipe_divider    = out_q.pipe_divider;
  assign res.new_back_porch  = out_q.new_back_porch;
  assign res.new_front_porch = out_q.new_front_porch;
  assign res.new_sync_width  = out_q.new_sync_width;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> busy_q) else $error("result without a request");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> !ovalid_q || res.ready) else $error("result beat overwritten");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> out_q.status <= pcpp_pkg::StZeroDiv) else $error("bad status");

endmodule
`default_nettype wire
